// ----- rtl/serial_motor_command_decoder_unit_assert.svh -----
// Assertion macros for the serial motor command decoder.
`ifndef SERIAL_MOTOR_COMMAND_DECODER_UNIT_ASSERT_SVH
`define SERIAL_MOTOR_COMMAND_DECODER_UNIT_ASSERT_SVH

`ifndef ASSERT_OFF
// Same-cycle implication, sampled on clk, off during rst.
`define SMCD_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
// Next-cycle implication, sampled on clk, off during rst.
`define SMCD_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`else
`define SMCD_ASSERT_NOW(lbl, ante, cons, msg)
`define SMCD_ASSERT_NEXT(lbl, ante, cons, msg)
`endif

`endif

// ----- rtl/smcd_pkg.sv -----
// Shared types, codes and constants of the serial motor command decoder.
`default_nettype none
package smcd_pkg;

  // Character codes
  localparam logic [7:0] CHAR_LF    = 8'h0A;
  localparam logic [7:0] CHAR_CR    = 8'h0D;
  localparam logic [7:0] CHAR_F     = 8'h46;
  localparam logic [7:0] CHAR_B     = 8'h42;
  localparam logic [7:0] CHAR_L     = 8'h4C;
  localparam logic [7:0] CHAR_R     = 8'h52;
  localparam logic [7:0] CHAR_S     = 8'h53;
  localparam logic [7:0] CHAR_M     = 8'h4D;
  localparam logic [7:0] CHAR_O     = 8'h4F;
  localparam logic [7:0] CHAR_C     = 8'h43;
  localparam logic [7:0] CHAR_SPACE = 8'h20;
  localparam logic [7:0] CHAR_TAB   = 8'h09;
  localparam logic [7:0] CHAR_VT    = 8'h0B;
  localparam logic [7:0] CHAR_FF    = 8'h0C;
  localparam logic [7:0] CHAR_PLUS  = 8'h2B;
  localparam logic [7:0] CHAR_MINUS = 8'h2D;
  localparam logic [7:0] CHAR_ZERO  = 8'h30;
  localparam logic [7:0] CHAR_NINE  = 8'h39;

  localparam logic [7:0]  SPEED_MAX   = 8'd255;
  localparam logic [15:0] MAG_MAX     = 16'hFFFF;
  localparam logic [15:0] IDLE_MAX    = 16'hFFFF;
  localparam logic [7:0]  SERVO_RESET = 8'd90;

  // Register defaults and indexes
  localparam logic [7:0]  OPEN_RESET    = 8'd70;
  localparam logic [7:0]  CLOSE_RESET   = 8'd120;
  localparam logic [7:0]  STEP_RESET    = 8'd8;
  localparam logic [15:0] TIMEOUT_RESET = 16'd500;

  localparam int CFG_IDX_W  = 8;
  localparam int CFG_DATA_W = 16;
  localparam logic [CFG_IDX_W-1:0] CFG_OPEN    = 8'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_CLOSE   = 8'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_STEP    = 8'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_TIMEOUT = 8'd3;

  // Queue between front and back
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCOUNT_W    = $clog2(QUEUE_DEPTH + 1);

  // Operation codes carried through the queue
  typedef logic [2:0] op_t;
  localparam op_t OP_NONE  = 3'd0;
  localparam op_t OP_TICK  = 3'd1;
  localparam op_t OP_DRIVE = 3'd2;
  localparam op_t OP_MODE  = 3'd3;
  localparam op_t OP_OPEN  = 3'd4;
  localparam op_t OP_CLOSE = 3'd5;

  // Drive kinds
  typedef logic [2:0] dk_t;
  localparam dk_t DK_STOP  = 3'd0;
  localparam dk_t DK_FWD   = 3'd1;
  localparam dk_t DK_BACK  = 3'd2;
  localparam dk_t DK_LEFT  = 3'd3;
  localparam dk_t DK_RIGHT = 3'd4;

  localparam logic [3:0] PINS_STOP  = 4'd0;
  localparam logic [3:0] PINS_FWD   = 4'd6;
  localparam logic [3:0] PINS_BACK  = 4'd9;
  localparam logic [3:0] PINS_LEFT  = 4'd5;
  localparam logic [3:0] PINS_RIGHT = 4'd10;

  typedef struct packed {
    op_t        op;
    dk_t        kind;
    logic [7:0] speed;
    logic       mode_one;
  } entry_t;

  typedef struct packed {
    logic [7:0]  open_angle;
    logic [7:0]  close_angle;
    logic [7:0]  claw_step;
    logic [15:0] link_timeout_ms;
  } cfg_t;

  typedef struct packed {
    logic                full;
    logic                nonempty;
  } q_status_t;

  typedef struct packed {
    logic [3:0] bridge_pins;
    logic [7:0] motor_duty;
    logic       movement_on;
    logic [7:0] claw_angle;
  } result_t;

  function automatic logic [3:0] drive_pins(input dk_t kind);
    logic [3:0] pins;
    unique case (kind)
      DK_FWD:   pins = PINS_FWD;
      DK_BACK:  pins = PINS_BACK;
      DK_LEFT:  pins = PINS_LEFT;
      DK_RIGHT: pins = PINS_RIGHT;
      default:  pins = PINS_STOP;
    endcase
    return pins;
  endfunction

endpackage
`default_nettype wire

// ----- rtl/smcd_front.sv -----
// Line collector and parser: turns each accepted item into one queue entry.
`default_nettype none
module smcd_front #(
  parameter int LINE_CHARS = 11
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             take,
  input  wire logic             is_tick,
  input  wire logic [7:0]       rx_byte,
  output smcd_pkg::entry_t      entry
);
  import smcd_pkg::*;

  localparam int CW = $clog2(LINE_CHARS + 1);
  localparam logic [CW-1:0] LIMIT = CW'(LINE_CHARS);

  localparam logic [1:0] PH_SPACE  = 2'd0;
  localparam logic [1:0] PH_SIGN   = 2'd1;
  localparam logic [1:0] PH_DIGITS = 2'd2;
  localparam logic [1:0] PH_DONE   = 2'd3;

  logic [CW-1:0] char_count, char_count_next;
  logic [7:0]    letter, letter_next;
  logic [1:0]    phase, phase_next;
  logic          negative, negative_next;
  logic [15:0]   magnitude, magnitude_next;

  logic        is_digit, is_space, is_sign;
  logic [19:0] mag_wide;

  assign is_digit = (rx_byte >= CHAR_ZERO) && (rx_byte <= CHAR_NINE);
  assign is_space = (rx_byte == CHAR_SPACE) || (rx_byte == CHAR_TAB) ||
                    (rx_byte == CHAR_VT) || (rx_byte == CHAR_FF);
  assign is_sign  = (rx_byte == CHAR_PLUS) || (rx_byte == CHAR_MINUS);
  // mag * 10 + digit as shift-add
  assign mag_wide = {1'b0, magnitude, 3'b000} + {3'b000, magnitude, 1'b0} +
                    {16'd0, rx_byte[3:0] - CHAR_ZERO[3:0]};

  always_comb begin
    char_count_next = char_count;
    letter_next     = letter;
    phase_next      = phase;
    negative_next   = negative;
    magnitude_next  = magnitude;
    entry.op        = OP_NONE;
    entry.kind      = DK_STOP;
    entry.speed     = negative ? 8'd0 :
                      ((magnitude > {8'd0, SPEED_MAX}) ? SPEED_MAX : magnitude[7:0]);
    entry.mode_one  = !negative && (magnitude == 16'd1);
    if (is_tick) begin
      entry.op = OP_TICK;
    end else if (rx_byte == CHAR_LF) begin
      if (char_count != '0) begin
        unique case (letter)
          CHAR_F:  begin entry.op = OP_DRIVE; entry.kind = DK_FWD;   end
          CHAR_B:  begin entry.op = OP_DRIVE; entry.kind = DK_BACK;  end
          CHAR_L:  begin entry.op = OP_DRIVE; entry.kind = DK_LEFT;  end
          CHAR_R:  begin entry.op = OP_DRIVE; entry.kind = DK_RIGHT; end
          CHAR_S:  begin entry.op = OP_DRIVE; entry.kind = DK_STOP;  end
          CHAR_M:  entry.op = OP_MODE;
          CHAR_O:  entry.op = OP_OPEN;
          CHAR_C:  entry.op = OP_CLOSE;
          default: entry.op = OP_NONE;
        endcase
      end
      char_count_next = '0;
      letter_next     = 8'd0;
      phase_next      = PH_SPACE;
      negative_next   = 1'b0;
      magnitude_next  = 16'd0;
    end else if (rx_byte != CHAR_CR) begin
      if (char_count < LIMIT) begin
        char_count_next = char_count + 1'b1;
        if (char_count == '0) begin
          letter_next = rx_byte;
        end else begin
          priority if (phase == PH_SPACE && is_space) begin
            phase_next = PH_SPACE;
          end else if (phase == PH_SPACE && is_sign) begin
            negative_next = (rx_byte == CHAR_MINUS);
            phase_next    = PH_SIGN;
          end else if (phase == PH_DONE) begin
            phase_next = PH_DONE;
          end else if (!is_digit) begin
            phase_next = PH_DONE;
          end else begin
            phase_next     = PH_DIGITS;
            magnitude_next = (mag_wide > {4'd0, MAG_MAX}) ? MAG_MAX : mag_wide[15:0];
          end
        end
      end else begin
        // overlong line: drop the byte and restart collection
        char_count_next = '0;
        letter_next     = 8'd0;
        phase_next      = PH_SPACE;
        negative_next   = 1'b0;
        magnitude_next  = 16'd0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      char_count <= '0;
      letter     <= 8'd0;
      phase      <= PH_SPACE;
      negative   <= 1'b0;
      magnitude  <= 16'd0;
    end else if (take) begin
      char_count <= char_count_next;
      letter     <= letter_next;
      phase      <= phase_next;
      negative   <= negative_next;
      magnitude  <= magnitude_next;
    end
  end

endmodule
`default_nettype wire

// ----- rtl/smcd_queue.sv -----
// Small FIFO of decoded entries between the parser and the executor.
`default_nettype none
module smcd_queue (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          push,
  input  wire smcd_pkg::entry_t push_entry,
  input  wire logic          pop,
  output smcd_pkg::entry_t   head,
  output smcd_pkg::q_status_t status
);
  import smcd_pkg::*;

  entry_t              slots [QUEUE_DEPTH];
  logic [QPTR_W-1:0]   wr_ptr, rd_ptr;
  logic [QCOUNT_W-1:0] count;

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + 1'b1;
      if (pop)  rd_ptr <= rd_ptr + 1'b1;
      unique case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

  assign head            = slots[rd_ptr];
  assign status.full     = (count == QCOUNT_W'(QUEUE_DEPTH));
  assign status.nonempty = (count != '0);

endmodule
`default_nettype wire

// ----- rtl/smcd_back.sv -----
// Executor: applies queue entries to drive, mode, claw and idle state; holds the result.
`default_nettype none
module smcd_back (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire smcd_pkg::cfg_t   cfg,
  input  wire logic        have_entry,
  input  wire smcd_pkg::entry_t entry,
  output logic             pop,
  output logic             res_valid,
  input  wire logic        res_ready,
  output smcd_pkg::result_t res
);
  import smcd_pkg::*;

  logic        mode, mode_next;
  dk_t         kind, kind_next;
  logic [7:0]  speed, speed_next;
  logic [7:0]  angle, angle_next;
  logic [15:0] idle, idle_next;

  logic [7:0] target, lo, hi, stepped;
  logic [8:0] up_sum;
  logic [3:0] pins;

  assign pop = have_entry && (!res_valid || res_ready);

  // Claw step toward target, then clamp between the two configured angles
  always_comb begin
    target  = (entry.op == OP_OPEN) ? cfg.open_angle : cfg.close_angle;
    lo      = (cfg.open_angle < cfg.close_angle) ? cfg.open_angle : cfg.close_angle;
    hi      = (cfg.open_angle < cfg.close_angle) ? cfg.close_angle : cfg.open_angle;
    up_sum  = {1'b0, angle} + {1'b0, cfg.claw_step};
    stepped = angle;
    if (angle < target) begin
      stepped = (up_sum > {1'b0, target}) ? target : up_sum[7:0];
    end else if (angle > target) begin
      stepped = ((angle < cfg.claw_step) || (angle - cfg.claw_step < target)) ?
                target : angle - cfg.claw_step;
    end
    if (stepped < lo) stepped = lo;
    if (stepped > hi) stepped = hi;
  end

  always_comb begin
    mode_next  = mode;
    kind_next  = kind;
    speed_next = speed;
    angle_next = angle;
    idle_next  = idle;
    unique case (entry.op)
      OP_TICK: begin
        if (idle != IDLE_MAX) idle_next = idle + 16'd1;
      end
      OP_DRIVE: begin
        if (mode || entry.kind == DK_STOP) begin
          kind_next  = entry.kind;
          speed_next = (entry.kind == DK_STOP) ? 8'd0 : entry.speed;
          idle_next  = 16'd0;
        end
      end
      OP_MODE: begin
        if (entry.mode_one) begin
          mode_next = 1'b1;
        end else begin
          mode_next  = 1'b0;
          kind_next  = DK_STOP;
          speed_next = 8'd0;
        end
      end
      OP_OPEN, OP_CLOSE: angle_next = stepped;
      default: ;
    endcase
    if (idle_next > cfg.link_timeout_ms) begin
      kind_next  = DK_STOP;
      speed_next = 8'd0;
    end
    pins = mode_next ? drive_pins(kind_next) : PINS_STOP;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode      <= 1'b0;
      kind      <= DK_STOP;
      speed     <= 8'd0;
      angle     <= SERVO_RESET;
      idle      <= 16'd0;
      res_valid <= 1'b0;
    end else begin
      if (pop) begin
        mode  <= mode_next;
        kind  <= kind_next;
        speed <= speed_next;
        angle <= angle_next;
        idle  <= idle_next;
      end
      if (pop) res_valid <= 1'b1;
      else if (res_ready) res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      res.bridge_pins <= pins;
      res.motor_duty  <= (pins != PINS_STOP) ? speed_next : 8'd0;
      res.movement_on <= mode_next;
      res.claw_angle  <= angle_next;
    end
  end

endmodule
`default_nettype wire

// ----- rtl/serial_motor_command_decoder_unit.sv -----
// Top level of the serial motor command decoder: ports, registers, front, queue, back.
//
// Input stream: one beat per item. s_axis_tuser = 0 carries a received serial
// byte in s_axis_tdata; s_axis_tuser = 1 is a one millisecond tick (tdata unused).
// Bytes build newline-ended command lines (CR ignored); a newline runs the line.
// Output stream: exactly one result beat per input beat, in order, giving the
// H-bridge pins, PWM duty, movement mode and claw angle after that item.
// Config channel: cfg_index 0..3 selects open angle, close angle, claw step and
// link timeout in ms; other indexes are ignored. cfg_ready is always high;
// write only while no item is in flight.
// Timing: the parser is combinational and writes the queue at the accepting edge;
// the executor pops the queue head and loads its output register, which drives
// m_axis_tvalid. Throughput: one item per cycle while the receiver takes results;
// a four-entry queue sits between the parser and the executor.
// Reset (rst, synchronous): line state cleared, movement off, drive stopped,
// claw at 90 degrees, idle count zero, registers back to their defaults.
// Receiver stall: the output beat holds, the queue fills, and s_axis_tready
// drops once four entries wait.
`default_nettype none
`include "serial_motor_command_decoder_unit_assert.svh"
module serial_motor_command_decoder_unit #(
  parameter int LINE_CHARS = 11
) (
  input  wire logic        clk,
  input  wire logic        rst,
  // command input
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [7:0]  s_axis_tdata,   // [7:0] rx_byte
  input  wire logic        s_axis_tuser,   // [0] command (0 byte, 1 tick)
  // result output
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [23:0]      m_axis_tdata,   // [3:0] bridge_pins, [11:4] motor_duty,
                                           // [12] movement_on, [20:13] claw_angle
  // configuration write
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [smcd_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [smcd_pkg::CFG_DATA_W-1:0] cfg_data
);
  import smcd_pkg::*;

  cfg_t      cfg;
  entry_t    front_entry, head;
  q_status_t q_status;
  result_t   res;
  logic      take, pop;

  // Configuration registers
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.open_angle      <= OPEN_RESET;
      cfg.close_angle     <= CLOSE_RESET;
      cfg.claw_step       <= STEP_RESET;
      cfg.link_timeout_ms <= TIMEOUT_RESET;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_OPEN:    cfg.open_angle      <= cfg_data[7:0];
        CFG_CLOSE:   cfg.close_angle     <= cfg_data[7:0];
        CFG_STEP:    cfg.claw_step       <= cfg_data[7:0];
        CFG_TIMEOUT: cfg.link_timeout_ms <= cfg_data;
        default: ;
      endcase
    end
  end

  // Accept a beat whenever the queue has room
  assign s_axis_tready = !q_status.full;
  assign take          = s_axis_tvalid && s_axis_tready;

  smcd_front #(
    .LINE_CHARS (LINE_CHARS)
  ) u_front (
    .clk     (clk),
    .rst     (rst),
    .take    (take),
    .is_tick (s_axis_tuser),
    .rx_byte (s_axis_tdata),
    .entry   (front_entry)
  );

  smcd_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (take),
    .push_entry (front_entry),
    .pop        (pop),
    .head       (head),
    .status     (q_status)
  );

  smcd_back u_back (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .have_entry (q_status.nonempty),
    .entry      (head),
    .pop        (pop),
    .res_valid  (m_axis_tvalid),
    .res_ready  (m_axis_tready),
    .res        (res)
  );

  assign m_axis_tdata = {3'b000, res.claw_angle, res.movement_on, res.motor_duty,
                         res.bridge_pins};

  // Conditions checked below
  logic beat_off, beat_stop, res_idle, drain_due;
  assign res_idle  = (res.bridge_pins == PINS_STOP) && (res.motor_duty == 8'd0);
  assign beat_off  = m_axis_tvalid && !res.movement_on;
  assign beat_stop = m_axis_tvalid && (res.bridge_pins == PINS_STOP);
  assign drain_due = q_status.nonempty && (!m_axis_tvalid || m_axis_tready);

  // With movement off, the bridge must show stop and zero duty
  `SMCD_ASSERT_NOW(ast_off_means_stop, beat_off, res_idle, "drive active while movement is off")
  // Nonzero duty only with an active pin pattern
  `SMCD_ASSERT_NOW(ast_duty_needs_pins, beat_stop, res_idle, "duty driven with stopped bridge")
  // A waiting entry with a free output stage yields a beat next cycle
  `SMCD_ASSERT_NEXT(ast_queue_drains, drain_due, m_axis_tvalid, "queued entry not delivered")

endmodule
`default_nettype wire
